/* rtl/usb_hdlc_frame_reassembler_defines.svh */
// Assertion macros for the USB frame reassembler.
`ifndef USB_HDLC_FRAME_REASSEMBLER_DEFINES_SVH
`define USB_HDLC_FRAME_REASSEMBLER_DEFINES_SVH

// Condition that must hold at every clock outside reset.
`define UHFR_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Consequent that must hold the cycle after the antecedent.
`define UHFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/uhfr_pkg.sv */
// Types, constants and helpers shared by the USB frame reassembler.
package uhfr_pkg;

  localparam int FRAME_BYTES_DEF  = 512;
  localparam int PACKET_BYTES_DEF = 64;
  localparam int HOLD_BYTES       = 3;
  localparam int FRAME_LEN_W      = 10;
  localparam int PLEN_W           = 7;
  localparam int Q_DEPTH          = 4;
  localparam int Q_PTR_W          = $clog2(Q_DEPTH);
  localparam int Q_CNT_W          = $clog2(Q_DEPTH + 1);

  localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_MAX = '1;
  localparam logic [7:0] STATUS_ABORT = 8'hff;
  localparam logic [7:0] STATUS_OK    = 8'h00;

  typedef enum logic {
    ACT_HEADER  = 1'b0,
    ACT_PAYLOAD = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_BYTE    = 2'd1,
    KIND_VERDICT = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    VERD_GOOD     = 3'd0,
    VERD_SHORT    = 3'd1,
    VERD_EMPTY    = 3'd2,
    VERD_ABORT    = 3'd3,
    VERD_CRC      = 3'd4,
    VERD_OVERFLOW = 3'd5
  } verdict_e;

  typedef struct packed {
    action_e           action;
    logic [7:0]        data;
    logic [7:0]        fill_flags;
    logic [PLEN_W-1:0] payload_length;
  } in_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] byte_out;
    logic       frame_end;
    verdict_e   verdict;
    logic       state_changed;
    logic [3:0] tx_ready;
    logic       last;
  } out_t;

  typedef struct packed {
    out_t r0;
    out_t r1;
    logic two;
  } entry_t;

  function automatic verdict_e frame_verdict(input logic ovf,
                                             input logic [FRAME_LEN_W-1:0] flen,
                                             input logic [7:0] status);
    verdict_e v;
    if (ovf) v = VERD_OVERFLOW;
    else if (flen < FRAME_LEN_W'(HOLD_BYTES)) v = VERD_SHORT;
    else if (flen == FRAME_LEN_W'(HOLD_BYTES)) v = VERD_EMPTY;
    else if (status == STATUS_ABORT) v = VERD_ABORT;
    else if (status != STATUS_OK) v = VERD_CRC;
    else v = VERD_GOOD;
    return v;
  endfunction

endpackage

/* rtl/usb_hdlc_frame_reassembler.sv */
// USB receive frame reassembler, top level.
// Takes one transaction per cycle while its result queue has room.
// A transaction's results are registered in the queue, then in the back end.
// With out_ready_i high, results leave one per cycle, an item's two in turn.
// Reset clears all frame and packet state, the line-state register and the queue.
module usb_hdlc_frame_reassembler #(
  parameter int FrameBytes  = uhfr_pkg::FRAME_BYTES_DEF,
  parameter int PacketBytes = uhfr_pkg::PACKET_BYTES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [3:0]     cfg_wdata_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  uhfr_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output uhfr_pkg::out_t out_o
);
  import uhfr_pkg::*;

  entry_t push_entry, pop_entry;
  logic   push, full, pop, empty;

  uhfr_front #(
    .FrameBytes (FrameBytes),
    .PacketBytes(PacketBytes)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .push_o     (push),
    .entry_o    (push_entry),
    .full_i     (full)
  );

  uhfr_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(push_entry),
    .full_o (full),
    .pop_i  (pop),
    .rdata_o(pop_entry),
    .empty_o(empty)
  );

  uhfr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .entry_i    (pop_entry),
    .empty_i    (empty),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

endmodule

/* rtl/uhfr_front.sv */
// Front end: accepts items, tracks packet and frame state, builds result entries.
module uhfr_front #(
  parameter int FrameBytes  = uhfr_pkg::FRAME_BYTES_DEF,
  parameter int PacketBytes = uhfr_pkg::PACKET_BYTES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [3:0]       cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  uhfr_pkg::in_t    in_i,
  output logic             push_o,
  output uhfr_pkg::entry_t entry_o,
  input  logic             full_i
);
  import uhfr_pkg::*;

  logic [3:0]             exp_state_q;
  logic [7:0]             hb_q [HOLD_BYTES];
  logic [7:0]             hb_d [HOLD_BYTES];
  logic [FRAME_LEN_W-1:0] flen_q, flen_d, flen_inc;
  logic [PLEN_W-1:0]      rem_q, rem_d, rem_dec, plen;
  logic                   eof_q, eof_d, disc_q, disc_d, ovf_q, ovf_d;
  logic                   accept, ends, emit_byte;
  logic                   has_res;
  logic                   verd_push;
  out_t                   hdr_res, byte_res, verd_res;
  verdict_e               verd;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && has_res;
  assign verd_push  = push_o && (entry_o.r0.kind == KIND_VERDICT ||
                                 (entry_o.two && entry_o.r1.kind == KIND_VERDICT));

  assign plen     = (in_i.payload_length > PLEN_W'(PacketBytes)) ?
                    PLEN_W'(PacketBytes) : in_i.payload_length;
  assign rem_dec  = rem_q - PLEN_W'(1);
  assign flen_inc = (flen_q < FRAME_LEN_MAX) ? flen_q + FRAME_LEN_W'(1) : flen_q;

  always_comb begin
    hdr_res               = '0;
    hdr_res.kind          = KIND_HEADER;
    hdr_res.state_changed = in_i.data[7:4] != exp_state_q;
    hdr_res.tx_ready      = ~{in_i.fill_flags[6], in_i.fill_flags[2],
                              in_i.fill_flags[0], in_i.fill_flags[4]};
    byte_res              = '0;
    byte_res.kind         = KIND_BYTE;
    byte_res.byte_out     = hb_q[0];
    byte_res.frame_end    = ends;
    verd_res              = '0;
    verd_res.kind         = KIND_VERDICT;
    verd_res.verdict      = verd;
  end

  always_comb begin
    hb_d      = hb_q;
    flen_d    = flen_q;
    rem_d     = rem_q;
    eof_d     = eof_q;
    disc_d    = disc_q;
    ovf_d     = ovf_q;
    ends      = 1'b0;
    emit_byte = 1'b0;
    verd      = VERD_GOOD;
    has_res   = 1'b0;
    entry_o   = '0;
    if (in_i.action == ACT_HEADER) begin
      has_res = 1'b1;
      rem_d   = plen;
      eof_d   = in_i.data[0];
      disc_d  = 1'b0;
      if ({1'b0, flen_q} + {{(FRAME_LEN_W + 1 - PLEN_W){1'b0}}, plen} >
          (FRAME_LEN_W + 1)'(FrameBytes)) begin
        disc_d = 1'b1;
        eof_d  = 1'b0;
        ovf_d  = 1'b1;
      end
      entry_o.r0 = hdr_res;
      if (plen == '0) begin
        disc_d = 1'b0;
        if (eof_d) begin
          verd       = frame_verdict(ovf_d, flen_q, hb_q[HOLD_BYTES-1]);
          entry_o.r1 = verd_res;
          entry_o.two = 1'b1;
          flen_d = '0;
          ovf_d  = 1'b0;
          eof_d  = 1'b0;
          for (int i = 0; i < HOLD_BYTES; i++) hb_d[i] = '0;
        end
      end
    end else if (rem_q != '0) begin
      rem_d = rem_dec;
      if (disc_q) begin
        if (rem_dec == '0) disc_d = 1'b0;
      end else begin
        ends      = (rem_dec == '0) && eof_q;
        emit_byte = flen_q >= FRAME_LEN_W'(HOLD_BYTES);
        for (int i = 0; i < HOLD_BYTES - 1; i++) hb_d[i] = hb_q[i+1];
        hb_d[HOLD_BYTES-1] = in_i.data;
        flen_d = flen_inc;
        verd   = frame_verdict(ovf_q, flen_inc, in_i.data);
        has_res = emit_byte || ends;
        if (emit_byte) begin
          entry_o.r0  = byte_res;
          entry_o.r1  = verd_res;
          entry_o.two = ends;
        end else begin
          entry_o.r0 = verd_res;
        end
        if (ends) begin
          flen_d = '0;
          ovf_d  = 1'b0;
          eof_d  = 1'b0;
          for (int i = 0; i < HOLD_BYTES; i++) hb_d[i] = '0;
        end
      end
    end
    entry_o.r0.last = !entry_o.two;
    entry_o.r1.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_state_q <= '0;
    end else if (cfg_we_i) begin
      exp_state_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HOLD_BYTES; i++) hb_q[i] <= '0;
      flen_q <= '0;
      rem_q  <= '0;
      eof_q  <= 1'b0;
      disc_q <= 1'b0;
      ovf_q  <= 1'b0;
    end else if (accept) begin
      hb_q   <= hb_d;
      flen_q <= flen_d;
      rem_q  <= rem_d;
      eof_q  <= eof_d;
      disc_q <= disc_d;
      ovf_q  <= ovf_d;
    end
  end

`include "usb_hdlc_frame_reassembler_defines.svh"

  `UHFR_ASSERT(a_flen_bound, flen_q <= FRAME_LEN_W'(FrameBytes), "frame length over limit")
  `UHFR_ASSERT(a_disc_pending, !disc_q || rem_q != '0, "discard without pending bytes")
  `UHFR_ASSERT(a_rem_bound, rem_q <= PLEN_W'(PacketBytes), "packet remaining over limit")
  `UHFR_ASSERT_NEXT(a_verdict_clears, verd_push, flen_q == '0 && !ovf_q, "frame not cleared")

endmodule

/* rtl/uhfr_fifo.sv */
// Small queue of result entries between the front and back ends.
module uhfr_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  uhfr_pkg::entry_t wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output uhfr_pkg::entry_t rdata_o,
  output logic             empty_o
);
  import uhfr_pkg::*;

  entry_t               mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wptr_q, rptr_q;
  logic [Q_CNT_W-1:0]   cnt_q;
  logic                 do_push, do_pop;

  assign full_o  = cnt_q == Q_CNT_W'(Q_DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + Q_PTR_W'(1);
      if (do_pop) rptr_q <= rptr_q + Q_PTR_W'(1);
      if (do_push && !do_pop) cnt_q <= cnt_q + Q_CNT_W'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - Q_CNT_W'(1);
    end
  end

endmodule

/* rtl/uhfr_back.sv */
// Back end: presents queued results one per cycle while out_ready_i is high.
module uhfr_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  uhfr_pkg::entry_t entry_i,
  input  logic             empty_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output uhfr_pkg::out_t   out_o
);
  import uhfr_pkg::*;

  entry_t cur_q;
  logic   valid_q, sel_q;
  logic   done, load;

  assign done        = out_valid_o && out_ready_i;
  assign load        = !valid_q || (done && (sel_q || !cur_q.two));
  assign pop_o       = load && !empty_i;
  assign out_valid_o = valid_q;
  assign out_o       = sel_q ? cur_q.r1 : cur_q.r0;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else if (load) begin
      valid_q <= !empty_i;
      sel_q   <= 1'b0;
    end else if (done) begin
      sel_q <= 1'b1;
    end
  end

endmodule
